[hdl/stt_pkg.sv]
// Shared types, codes and character classification for the source text tokenizer.
package stt_pkg;

  localparam int unsigned STT_MAX_TEXT = 65536;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_NUM   = 3'd1,
    MODE_CHR   = 3'd2,
    MODE_STR   = 3'd3,
    MODE_IDENT = 3'd4,
    MODE_OP    = 3'd5,
    MODE_ERR   = 3'd6
  } scan_mode_t;

  localparam logic [3:0] KIND_INT     = 4'd0;
  localparam logic [3:0] KIND_FLOAT   = 4'd1;
  localparam logic [3:0] KIND_CHR     = 4'd2;
  localparam logic [3:0] KIND_STR     = 4'd3;
  localparam logic [3:0] KIND_IDENT   = 4'd4;
  localparam logic [3:0] KIND_KEYWORD = 4'd5;
  localparam logic [3:0] KIND_OP      = 4'd6;
  localparam logic [3:0] KIND_END     = 4'd7;
  localparam logic [3:0] KIND_ERR     = 4'd8;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_DOT    = 2'd1;
  localparam logic [1:0] ERR_CHAR   = 2'd2;
  localparam logic [1:0] ERR_LENGTH = 2'd3;

  localparam logic [4:0] OP_SEMI   = 5'd0;
  localparam logic [4:0] OP_LPAREN = 5'd1;
  localparam logic [4:0] OP_RPAREN = 5'd2;
  localparam logic [4:0] OP_LBRACE = 5'd3;
  localparam logic [4:0] OP_RBRACE = 5'd4;
  localparam logic [4:0] OP_PLUS   = 5'd5;
  localparam logic [4:0] OP_MINUS  = 5'd6;
  localparam logic [4:0] OP_STAR   = 5'd7;
  localparam logic [4:0] OP_SLASH  = 5'd8;
  localparam logic [4:0] OP_LT     = 5'd9;
  localparam logic [4:0] OP_GT     = 5'd10;
  localparam logic [4:0] OP_ASSIGN = 5'd11;
  localparam logic [4:0] OP_NOT    = 5'd12;
  localparam logic [4:0] OP_LE     = 5'd13;
  localparam logic [4:0] OP_GE     = 5'd14;
  localparam logic [4:0] OP_EQ     = 5'd15;
  localparam logic [4:0] OP_NE     = 5'd16;
  localparam logic [4:0] OP_INC    = 5'd17;
  localparam logic [4:0] OP_DEC    = 5'd18;

  localparam logic [4:0] NO_OP = 5'd0;
  localparam logic [3:0] NO_KW = 4'd0;

  localparam int KW_COUNT = 9;

  // Keyword spellings packed first character lowest, hence the reversed strings.
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'("fed"), 48'("tni"), 48'("gnirts"), 48'("taolf"), 48'("rahc"),
    48'("tnirp"), 48'("fi"), 48'("esle"), 48'("rof")
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd3, 3'd6, 3'd5, 3'd4, 3'd5, 3'd2, 3'd4, 3'd3
  };

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_word_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [3:0]  keyword_id;
    logic [4:0]  operator_id;
    logic [1:0]  error_code;
    logic        last_of_run;
  } token_word_t;

  typedef struct packed {
    scan_mode_t  mode;
    logic        dot_seen;
    logic [15:0] pos;
    logic [15:0] tok_start;
    logic [47:0] prefix;
    logic [2:0]  name_len;
    logic [7:0]  held;
  } scan_state_t;

  typedef struct packed {
    logic [1:0]       count;
    token_word_t [2:0] tok;
  } token_group_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] id;
  } op_match_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] id;
  } kw_match_t;

  typedef struct packed {
    scan_state_t st;
    logic        emit;
    token_word_t tok;
  } start_res_t;

  function automatic logic is_digit(logic [7:0] b);
    return b inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return b inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic may_pair(logic [7:0] b);
    return b inside {"+", "-", "<", ">", "=", "!"};
  endfunction

  function automatic op_match_t single_op(logic [7:0] b);
    op_match_t r;
    r.hit = 1'b1;
    case (b)
      ";":     r.id = OP_SEMI;
      "(":     r.id = OP_LPAREN;
      ")":     r.id = OP_RPAREN;
      "{":     r.id = OP_LBRACE;
      "}":     r.id = OP_RBRACE;
      "+":     r.id = OP_PLUS;
      "-":     r.id = OP_MINUS;
      "*":     r.id = OP_STAR;
      "/":     r.id = OP_SLASH;
      "<":     r.id = OP_LT;
      ">":     r.id = OP_GT;
      "=":     r.id = OP_ASSIGN;
      "!":     r.id = OP_NOT;
      default: begin
        r.hit = 1'b0;
        r.id  = NO_OP;
      end
    endcase
    return r;
  endfunction

  function automatic op_match_t pair_op(logic [7:0] first, logic [7:0] second);
    op_match_t r;
    r.hit = 1'b1;
    r.id  = NO_OP;
    if (second == "=" && first == "<") r.id = OP_LE;
    else if (second == "=" && first == ">") r.id = OP_GE;
    else if (second == "=" && first == "=") r.id = OP_EQ;
    else if (second == "=" && first == "!") r.id = OP_NE;
    else if (first == "+" && second == "+") r.id = OP_INC;
    else if (first == "-" && second == "-") r.id = OP_DEC;
    else r.hit = 1'b0;
    return r;
  endfunction

  function automatic kw_match_t keyword_of(logic [47:0] prefix, logic [2:0] len);
    kw_match_t r;
    r = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (len == KW_LEN[k] && prefix == KW_TEXT[k]) begin
        r.hit = 1'b1;
        r.id  = 4'(k);
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_len(logic [16:0] len);
    return len[16] ? 16'hFFFF : len[15:0];
  endfunction

  function automatic token_word_t make_tok(logic [3:0] kind, logic [15:0] start,
                                           logic [15:0] len, logic [3:0] kw,
                                           logic [4:0] op, logic [1:0] err);
    token_word_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.keyword_id   = kw;
    t.operator_id  = op;
    t.error_code   = err;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  function automatic scan_state_t clear_scan(scan_state_t cs);
    scan_state_t r;
    r           = cs;
    r.mode      = MODE_IDLE;
    r.dot_seen  = 1'b0;
    r.tok_start = '0;
    r.prefix    = '0;
    r.name_len  = '0;
    r.held      = '0;
    return r;
  endfunction

  function automatic token_word_t name_tok(scan_state_t cs, logic [15:0] len);
    kw_match_t m;
    m = keyword_of(cs.prefix, cs.name_len);
    if (m.hit) return make_tok(KIND_KEYWORD, cs.tok_start, len, m.id, NO_OP, ERR_NONE);
    return make_tok(KIND_IDENT, cs.tok_start, len, NO_KW, NO_OP, ERR_NONE);
  endfunction

  // Opens a new token at byte b, offset p, from the state between tokens.
  function automatic start_res_t start_token(scan_state_t cs, logic [7:0] b,
                                             logic [15:0] p);
    start_res_t r;
    op_match_t  so;
    so     = single_op(b);
    r.st   = clear_scan(cs);
    r.emit = 1'b0;
    r.tok  = '0;
    if (!is_space(b)) begin
      r.st.tok_start = p;
      if (is_digit(b)) begin
        r.st.mode = MODE_NUM;
      end else if (b == "'") begin
        r.st.mode = MODE_CHR;
      end else if (b == "\"") begin
        r.st.mode = MODE_STR;
      end else if (is_alpha(b)) begin
        r.st.mode     = MODE_IDENT;
        r.st.prefix   = {40'h0, b};
        r.st.name_len = 3'd1;
      end else if (may_pair(b)) begin
        r.st.mode = MODE_OP;
        r.st.held = b;
      end else if (so.hit) begin
        r.emit = 1'b1;
        r.tok  = make_tok(KIND_OP, p, 16'd1, NO_KW, so.id, ERR_NONE);
      end else begin
        r.emit    = 1'b1;
        r.tok     = make_tok(KIND_ERR, p, 16'd1, NO_KW, NO_OP, ERR_CHAR);
        r.st.mode = MODE_ERR;
      end
    end
    return r;
  endfunction

endpackage

[hdl/stt_step.sv]
// Per-word scanner update: next scan state and the group of tokens one text word yields.
module stt_step import stt_pkg::*; #(
  parameter int unsigned MAX_TEXT = STT_MAX_TEXT
) (
  input  scan_state_t  cur,
  input  text_word_t   word,
  output scan_state_t  nxt,
  output token_group_t group
);

  localparam int unsigned LIMIT    = (MAX_TEXT < 65536) ? MAX_TEXT : 65536;
  localparam logic [15:0] LAST_POS = 16'(LIMIT - 1);

  always_comb begin
    scan_state_t st;
    start_res_t  sr;
    op_match_t   pm;
    op_match_t   hm;
    op_match_t   fm;
    token_word_t cand [4];
    logic [3:0]  cv;
    logic [1:0]  cnt;
    logic [7:0]  b;
    logic [15:0] p;
    logic [15:0] s;
    logic        last;
    logic        take_start;

    b          = word.text_byte;
    last       = word.end_of_text;
    p          = cur.pos;
    s          = cur.tok_start;
    st         = cur;
    cv         = '0;
    cnt        = '0;
    take_start = 1'b0;
    for (int i = 0; i < 4; i++) cand[i] = '0;
    pm = pair_op(cur.held, b);
    hm = single_op(cur.held);

    if (cur.mode != MODE_ERR && !last && p == LAST_POS) begin
      st      = clear_scan(cur);
      st.mode = MODE_ERR;
      cv[0]   = 1'b1;
      cand[0] = make_tok(KIND_ERR, p, 16'd0, NO_KW, NO_OP, ERR_LENGTH);
    end else begin
      case (cur.mode)
        MODE_NUM: begin
          if (b == ".") begin
            if (cur.dot_seen) begin
              st      = clear_scan(cur);
              st.mode = MODE_ERR;
              cv[0]   = 1'b1;
              cand[0] = make_tok(KIND_ERR, p, 16'd1, NO_KW, NO_OP, ERR_DOT);
            end else begin
              st.dot_seen = 1'b1;
            end
          end else if (!is_digit(b)) begin
            cv[0]      = 1'b1;
            cand[0]    = make_tok(cur.dot_seen ? KIND_FLOAT : KIND_INT, s, p - s,
                                  NO_KW, NO_OP, ERR_NONE);
            take_start = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_alpha(b) || is_digit(b) || b == "_") begin
            if (cur.name_len < 3'd6) begin
              st.prefix[8*cur.name_len +: 8] = cur.prefix[8*cur.name_len +: 8] | b;
            end
            if (cur.name_len < 3'd7) st.name_len = cur.name_len + 3'd1;
          end else begin
            cv[0]      = 1'b1;
            cand[0]    = name_tok(cur, p - s);
            take_start = 1'b1;
          end
        end
        MODE_CHR: begin
          if (b == "'") begin
            cv[0]   = 1'b1;
            cand[0] = make_tok(KIND_CHR, s + 16'd1, p - s - 16'd1, NO_KW, NO_OP, ERR_NONE);
            st      = clear_scan(cur);
          end
        end
        MODE_STR: begin
          if (b == "\"") begin
            cv[0]   = 1'b1;
            cand[0] = make_tok(KIND_STR, s + 16'd1, p - s - 16'd1, NO_KW, NO_OP, ERR_NONE);
            st      = clear_scan(cur);
          end
        end
        MODE_OP: begin
          cv[0] = 1'b1;
          if (pm.hit) begin
            cand[0] = make_tok(KIND_OP, s, 16'd2, NO_KW, pm.id, ERR_NONE);
            st      = clear_scan(cur);
          end else begin
            cand[0]    = make_tok(KIND_OP, s, 16'd1, NO_KW, hm.id, ERR_NONE);
            take_start = 1'b1;
          end
        end
        MODE_ERR: begin
        end
        default: begin
          take_start = 1'b1;
        end
      endcase
    end

    sr = start_token(st, b, p);
    if (take_start) begin
      st      = sr.st;
      cv[1]   = sr.emit;
      cand[1] = sr.tok;
    end

    fm = single_op(st.held);
    if (last) begin
      case (st.mode)
        MODE_NUM: begin
          cv[2]   = 1'b1;
          cand[2] = make_tok(st.dot_seen ? KIND_FLOAT : KIND_INT, st.tok_start,
                             sat_len({1'b0, p} + 17'd1 - {1'b0, st.tok_start}),
                             NO_KW, NO_OP, ERR_NONE);
        end
        MODE_IDENT: begin
          cv[2]   = 1'b1;
          cand[2] = name_tok(st, sat_len({1'b0, p} + 17'd1 - {1'b0, st.tok_start}));
        end
        MODE_CHR: begin
          cv[2]   = 1'b1;
          cand[2] = make_tok(KIND_CHR, st.tok_start + 16'd1, p - st.tok_start,
                             NO_KW, NO_OP, ERR_NONE);
        end
        MODE_STR: begin
          cv[2]   = 1'b1;
          cand[2] = make_tok(KIND_STR, st.tok_start + 16'd1, p - st.tok_start,
                             NO_KW, NO_OP, ERR_NONE);
        end
        MODE_OP: begin
          cv[2]   = 1'b1;
          cand[2] = make_tok(KIND_OP, st.tok_start, 16'd1, NO_KW, fm.id, ERR_NONE);
        end
        default: begin
        end
      endcase
      cv[3]   = 1'b1;
      cand[3] = make_tok(KIND_END, p + 16'd1, 16'd0, NO_KW, NO_OP, ERR_NONE);
      st      = clear_scan(st);
      st.pos  = '0;
    end else begin
      st.pos = p + 16'd1;
    end

    group = '0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i] && cnt != 2'd3) begin
        group.tok[cnt] = cand[i];
        cnt            = cnt + 2'd1;
      end
    end
    if (cnt != 2'd0) group.tok[cnt - 2'd1].last_of_run = 1'b1;
    group.count = cnt;
    nxt         = st;
  end

endmodule

[hdl/stt_emit.sv]
// Register for one word's token group; hands the tokens out one per cycle unless stalled.
module stt_emit import stt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  token_group_t group,
  output logic         free,
  output logic         token_valid,
  input  logic         token_stall,
  output token_word_t  token_word
);

  token_word_t slot [3];
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic        pop;

  assign token_valid = (count != 2'd0);
  assign token_word  = slot[0];
  assign pop         = token_valid && !token_stall;
  assign free        = (count == 2'd0) || (count == 2'd1 && pop);

  always_comb begin
    count_next = count;
    if (load) count_next = group.count;
    else if (pop) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot[0] <= group.tok[0];
      slot[1] <= group.tok[1];
      slot[2] <= group.tok[2];
    end else if (pop) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("token group loaded over undelivered tokens");

  a_last_marks_final: assert property (@(posedge clk) disable iff (rst)
    (token_valid && count == 2'd1) |-> token_word.last_of_run)
    else $error("final token of a word lacks last_of_run");

  a_last_only_final: assert property (@(posedge clk) disable iff (rst)
    (token_valid && count != 2'd1) |-> !token_word.last_of_run)
    else $error("last_of_run set before the final token of a word");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && count == 2'd1 && !load) |=> !token_valid)
    else $error("token group did not drain");
`endif

endmodule

[hdl/source_text_tokenizer.sv]
// Top level of the source text tokenizer: input register, scan state and token output.
//
// Source text enters on the text channel, one byte per word, with end_of_text
// marking the last byte of a text. Token descriptors leave on the token
// channel, one per word; a byte yields zero to three tokens, and the last
// token caused by a byte carries last_of_run.
// A text byte is registered at acceptance; once the token group register is
// free, the scanner updates its state from the held byte and fills the token
// group register, from which the first token of the byte is offered.
// The text channel takes one byte per cycle while each byte yields at most
// one token and the receiver does not stall; a byte with more tokens holds
// the channel until its last token goes out of the single token output port.
// When the token receiver stalls, the held token stays steady and the text
// channel stalls once the input register and token group are both occupied.
// Reset clears the scan state and text offset and empties both registers; the
// block is ready for a new text in the cycle after reset is released. After
// each end_of_text byte the scan state returns to its reset value.
module source_text_tokenizer import stt_pkg::*; #(
  parameter int unsigned MAX_TEXT = STT_MAX_TEXT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  text_word_t  text_word,
  output logic        token_valid,
  input  logic        token_stall,
  output token_word_t token_word
);

  logic         held_valid;
  text_word_t   held_word;
  scan_state_t  state;
  scan_state_t  state_next;
  token_group_t group;
  logic         free;
  logic         advance;
  logic         accept;

  assign advance    = held_valid && free;
  assign text_stall = held_valid && !free;
  assign accept     = text_valid && !text_stall;

  stt_step #(
    .MAX_TEXT(MAX_TEXT)
  ) u_step (
    .cur   (state),
    .word  (held_word),
    .nxt   (state_next),
    .group (group)
  );

  stt_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .group       (group),
    .free        (free),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_word  (token_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      state      <= '0;
    end else begin
      if (accept) held_valid <= 1'b1;
      else if (advance) held_valid <= 1'b0;
      if (advance) state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held_word <= text_word;
  end

endmodule
